@@ rtl/m3h_pkg.sv @@
// Shared types, constants and helper functions for the MurmurHash3 stream hasher.
// Used by m3h_front, m3h_queue, m3h_back and murmur3_32_stream_hash.
// No dependencies.
package m3h_pkg;

    // Scramble, mix and finalization constants of MurmurHash3 x86_32.
    localparam logic [31:0] C1 = 32'hcc9e2d51;
    localparam logic [31:0] C2 = 32'h1b873593;
    localparam logic [31:0] MIX_ADD = 32'he6546b64;
    localparam logic [31:0] F1 = 32'h85ebca6b;
    localparam logic [31:0] F2 = 32'hc2b2ae35;

    // Byte count of a full word.
    localparam logic [2:0] WORD_BYTES = 3'd4;

    // One classified word on its way from the front to the back.
    typedef struct packed {
        logic [31:0] seed;
        logic [31:0] k;
        logic [2:0]  add_bytes;
        logic        full;
        logic        first;
        logic        last;
    } m3h_item_t;

    // Queue status seen by both sides.
    typedef struct packed {
        logic full;
        logic empty;
    } m3h_qstat_t;

    function automatic logic [31:0] rotl13(input logic [31:0] v);
        return {v[18:0], v[31:19]};
    endfunction

    function automatic logic [31:0] rotl15(input logic [31:0] v);
        return {v[16:0], v[31:17]};
    endfunction

    // Keeps the low bytes of a tail word; a full word keeps everything.
    function automatic logic [31:0] tail_mask(input logic [2:0] count);
        logic [31:0] m;
        case (count)
            3'd0:    m = 32'h0000_0000;
            3'd1:    m = 32'h0000_00ff;
            3'd2:    m = 32'h0000_ffff;
            3'd3:    m = 32'h00ff_ffff;
            default: m = 32'hffff_ffff;
        endcase
        return m;
    endfunction

endpackage

@@ rtl/m3h_front.sv @@
// Front end: accepts input beats, classifies each word as full or tail,
// and scrambles it in two multiplier stages. Depends on m3h_pkg.
module m3h_front
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [31:0]            seed,
    input  logic [31:0]            data_word,
    input  logic [2:0]             byte_count,
    input  logic                   last,
    input  m3h_pkg::m3h_qstat_t    q_stat,
    output logic                   q_push,
    output m3h_pkg::m3h_item_t     q_item
);

    logic                s1_v_reg;
    logic                s1_v_next;
    logic                s2_v_reg;
    logic                s2_v_next;
    logic                mid_reg;
    logic                mid_next;
    m3h_pkg::m3h_item_t  s1_reg;
    m3h_pkg::m3h_item_t  s1_next;
    m3h_pkg::m3h_item_t  s2_reg;
    m3h_pkg::m3h_item_t  s2_next;
    logic                s1_free;
    logic                s2_free;
    logic                accept;
    logic                is_full;

    // Stage flow: each stage takes new data when it is empty or draining.
    assign q_push   = s2_v_reg && !q_stat.full;
    assign s2_free  = !s2_v_reg || q_push;
    assign s1_free  = !s1_v_reg || s2_free;
    assign in_ready = s1_free;
    assign accept   = in_valid && s1_free;
    assign q_item   = s2_reg;

    // A word counts as full unless it is the last one with fewer than four bytes.
    assign is_full = !last || byte_count[2];

    // Classification and first scramble multiply.
    always_comb
    begin
        s1_next           = s1_reg;
        s1_v_next         = s1_v_reg;
        mid_next          = mid_reg;
        if (s1_free)
        begin
            s1_v_next         = accept;
            s1_next.seed      = seed;
            s1_next.k         = (data_word & m3h_pkg::tail_mask(is_full ?
                                 m3h_pkg::WORD_BYTES : byte_count)) * m3h_pkg::C1;
            s1_next.add_bytes = is_full ? m3h_pkg::WORD_BYTES : byte_count;
            s1_next.full      = is_full;
            s1_next.first     = !mid_reg;
            s1_next.last      = last;
        end
        if (accept)
        begin
            mid_next = !last;
        end
    end

    // Rotate and second scramble multiply.
    always_comb
    begin
        s2_next   = s2_reg;
        s2_v_next = s2_v_reg;
        if (s2_free)
        begin
            s2_v_next = s1_v_reg;
            s2_next   = s1_reg;
            s2_next.k = m3h_pkg::rotl15(s1_reg.k) * m3h_pkg::C2;
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg <= 1'b0;
            s2_v_reg <= 1'b0;
            mid_reg  <= 1'b0;
        end
        else
        begin
            s1_v_reg <= s1_v_next;
            s2_v_reg <= s2_v_next;
            mid_reg  <= mid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        s1_reg <= s1_next;
        s2_reg <= s2_next;
    end

endmodule

@@ rtl/m3h_queue.sv @@
// Short first-in first-out queue of classified words between front and back.
// Depends on m3h_pkg.
module m3h_queue
#(
    parameter int DEPTH = 4
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    input  m3h_pkg::m3h_item_t     push_item,
    input  logic                   pop,
    output m3h_pkg::m3h_item_t     head_item,
    output m3h_pkg::m3h_qstat_t    stat
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_IDX = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

    m3h_pkg::m3h_item_t  entry_reg [DEPTH];
    logic [PW-1:0]       wr_ptr_reg;
    logic [PW-1:0]       wr_ptr_next;
    logic [PW-1:0]       rd_ptr_reg;
    logic [PW-1:0]       rd_ptr_next;
    logic [CW-1:0]       count_reg;
    logic [CW-1:0]       count_next;

    assign stat.full  = (count_reg == FULL_COUNT);
    assign stat.empty = (count_reg == '0);
    assign head_item  = entry_reg[rd_ptr_reg];

    // Pointer and occupancy update.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_IDX) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_IDX) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

@@ rtl/m3h_back.sv @@
// Back end: runs the hash recurrence over queued words and, on the last word
// of a message, the pipelined avalanche finalization. Depends on m3h_pkg.
module m3h_back
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  m3h_pkg::m3h_item_t     q_item,
    input  m3h_pkg::m3h_qstat_t    q_stat,
    output logic                   q_pop,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [31:0]            hash
);

    logic [31:0] h_reg;
    logic [31:0] h_next;
    logic [31:0] total_reg;
    logic [31:0] total_next;
    logic [31:0] pre_reg;
    logic [31:0] pre_next;
    logic [31:0] a_reg;
    logic [31:0] a_next;
    logic [31:0] b_reg;
    logic [31:0] b_next;
    logic [31:0] out_reg;
    logic [31:0] out_next;
    logic        pre_v_reg;
    logic        pre_v_next;
    logic        a_v_reg;
    logic        a_v_next;
    logic        b_v_reg;
    logic        b_v_next;
    logic        out_v_reg;
    logic        out_v_next;
    logic        out_free;
    logic        b_free;
    logic        a_free;
    logic        pre_free;
    logic [31:0] h_base;
    logic [31:0] t_base;
    logic [31:0] h_mix;
    logic [31:0] h_rot;
    logic [31:0] x_a;
    logic [31:0] x_b;

    // Finalizer flow: a stage refills when it is empty or moving on.
    assign out_free = !out_v_reg || out_ready;
    assign b_free   = !b_v_reg || out_free;
    assign a_free   = !a_v_reg || b_free;
    assign pre_free = !pre_v_reg || a_free;

    // A last word waits until the finalizer can take it.
    assign q_pop = !q_stat.empty && (!q_item.last || pre_free);

    assign out_valid = out_v_reg;
    assign hash      = out_reg;

    // Hash recurrence; the first word of a message starts from its seed.
    always_comb
    begin
        h_base = q_item.first ? q_item.seed : h_reg;
        t_base = q_item.first ? 32'd0 : total_reg;
        h_mix  = h_base ^ q_item.k;
        h_rot  = m3h_pkg::rotl13(h_mix);
        h_next = h_reg;
        total_next = total_reg;
        pre_next   = pre_reg;
        if (q_pop)
        begin
            h_next     = q_item.full ? ((h_rot << 2) + h_rot + m3h_pkg::MIX_ADD) : h_mix;
            total_next = t_base + {29'd0, q_item.add_bytes};
            if (q_item.last)
            begin
                pre_next = h_next ^ total_next;
            end
        end
    end

    // Avalanche finalization; the multiplies sit in the a and b stages.
    always_comb
    begin
        x_a      = pre_reg ^ (pre_reg >> 16);
        x_b      = a_reg ^ (a_reg >> 13);
        a_next   = a_free ? x_a * m3h_pkg::F1 : a_reg;
        b_next   = b_free ? x_b * m3h_pkg::F2 : b_reg;
        out_next = out_free ? (b_reg ^ (b_reg >> 16)) : out_reg;

        pre_v_next = pre_free ? (q_pop && q_item.last) : pre_v_reg;
        a_v_next   = a_free ? pre_v_reg : a_v_reg;
        b_v_next   = b_free ? a_v_reg : b_v_reg;
        out_v_next = out_free ? b_v_reg : out_v_reg;
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pre_v_reg <= 1'b0;
            a_v_reg   <= 1'b0;
            b_v_reg   <= 1'b0;
            out_v_reg <= 1'b0;
            h_reg     <= 32'd0;
            total_reg <= 32'd0;
        end
        else
        begin
            pre_v_reg <= pre_v_next;
            a_v_reg   <= a_v_next;
            b_v_reg   <= b_v_next;
            out_v_reg <= out_v_next;
            h_reg     <= h_next;
            total_reg <= total_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        pre_reg <= pre_next;
        a_reg   <= a_next;
        b_reg   <= b_next;
        out_reg <= out_next;
    end

endmodule

@@ rtl/murmur3_32_stream_hash.sv @@
// Top level of the MurmurHash3 x86_32 stream hasher.
// Depends on m3h_pkg, m3h_front, m3h_queue and m3h_back.
//
// Usage:
//   The input channel (in_valid/in_ready) carries one little-endian 32-bit
//   word per beat, with seed, byte_count and last. The seed is read on the
//   first beat of a message. byte_count is honored only on the last beat;
//   earlier beats count as four bytes, and counts above four act as four.
//   The output channel (out_valid/out_ready) carries one hash per message.
//   Throughput is one word per cycle while the output side keeps up, set by the
//   hash recurrence in the back end; the scramble runs two multiplier stages
//   ahead of it in the front end.
//   On its way the hash is registered in the two scramble stages, the queue,
//   the recurrence and the three finalizer stages.
//   When the receiver stalls, the hash holds in the output register and the
//   finalizer, queue and front fill up before in_ready drops.
//   Reset clears all pipeline valid bits, the queue and the message state, so
//   the first beat after reset starts a new message.
module murmur3_32_stream_hash
#(
    parameter int QUEUE_DEPTH = 4
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [31:0] seed,
    input  logic [31:0] data_word,
    input  logic [2:0]  byte_count,
    input  logic        last,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] hash
);

    logic                 q_push;
    logic                 q_pop;
    m3h_pkg::m3h_item_t   push_item;
    m3h_pkg::m3h_item_t   head_item;
    m3h_pkg::m3h_qstat_t  q_stat;

    // Front end: accept, classify and scramble.
    m3h_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .seed       (seed),
        .data_word  (data_word),
        .byte_count (byte_count),
        .last       (last),
        .q_stat     (q_stat),
        .q_push     (q_push),
        .q_item     (push_item)
    );

    // Decoupling queue.
    m3h_queue #(.DEPTH(QUEUE_DEPTH)) u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_item (push_item),
        .pop       (q_pop),
        .head_item (head_item),
        .stat      (q_stat)
    );

    // Back end: recurrence and finalization.
    m3h_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_item    (head_item),
        .q_stat    (q_stat),
        .q_pop     (q_pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .hash      (hash)
    );

`ifndef SYNTHESIS
    // The front end never writes into a full queue.
    assert property (@(posedge clk) disable iff (!rst_n) q_push |-> !q_stat.full)
        else $error("queue push while full");

    // The back end never takes a word from an empty queue.
    assert property (@(posedge clk) disable iff (!rst_n) q_pop |-> !q_stat.empty)
        else $error("queue pop while empty");

    // A push without a pop leaves the queue non-empty next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
                     (q_push && !q_pop) |=> !q_stat.empty)
        else $error("queue lost a pushed word");
`endif

endmodule

@@ tb/sv/tb_top.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for the MurmurHash3 x86_32 stream hasher.
// Needs murmur3_32_stream_hash and its RTL files; the expected hashes are
// computed by an independent model kept in this file.
module tb_top;

    // MurmurHash3 x86_32 constants, kept here so the check does not lean on the RTL package.
    localparam logic [31:0] MUL_C1  = 32'hcc9e2d51;
    localparam logic [31:0] MUL_C2  = 32'h1b873593;
    localparam logic [31:0] ADD_N   = 32'he6546b64;
    localparam logic [31:0] AVAL_F1 = 32'h85ebca6b;
    localparam logic [31:0] AVAL_F2 = 32'hc2b2ae35;

    localparam int LONG_STALL   = 300;
    localparam int DRAIN_CYCLES = 16;

    logic        clk        = 1'b0;
    logic        rst_n      = 1'b0;
    logic        in_valid   = 1'b0;
    logic        in_ready;
    logic [31:0] seed       = '0;
    logic [31:0] data_word  = '0;
    logic [2:0]  byte_count = '0;
    logic        last       = 1'b0;
    logic        out_valid;
    logic        out_ready  = 1'b0;
    logic [31:0] hash;

    // Model state of the hash accumulator.
    logic [31:0] acc_hash   = '0;
    logic [31:0] acc_len    = '0;
    logic        in_message = 1'b0;

    // Hashes still owed by the block, oldest first.
    logic [31:0] hash_expect_q[$];

    int mismatch_count = 0;
    int send_idle_pct  = 0;
    int recv_idle_pct  = 0;
    int stall_seq      = 0;
    int stall_seen     = 0;
    int stall_left     = 0;

    murmur3_32_stream_hash DUT
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .seed       (seed),
        .data_word  (data_word),
        .byte_count (byte_count),
        .last       (last),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .hash       (hash)
    );

    always #10 clk = ~clk;

    // Hash arithmetic.
    function automatic logic [31:0] rotate_left(input logic [31:0] v, input int r);
        return (v << r) | (v >> (32 - r));
    endfunction

    function automatic logic [31:0] scramble_k(input logic [31:0] k);
        logic [31:0] t;
        t = k * MUL_C1;
        t = rotate_left(t, 15);
        t = t * MUL_C2;
        return t;
    endfunction

    function automatic logic [31:0] fold_word(input logic [31:0] h, input logic [31:0] w);
        logic [31:0] t;
        t = h ^ scramble_k(w);
        t = rotate_left(t, 13);
        return t * 32'd5 + ADD_N;
    endfunction

    function automatic logic [31:0] avalanche(input logic [31:0] h);
        logic [31:0] t;
        t = h ^ (h >> 16);
        t = t * AVAL_F1;
        t = t ^ (t >> 13);
        t = t * AVAL_F2;
        t = t ^ (t >> 16);
        return t;
    endfunction

    // Updates the model with one accepted beat and queues the hash at the end of a message.
    task automatic track_beat(input logic [31:0] s, input logic [31:0] w,
                              input logic [2:0] cnt, input logic fin);
        logic [31:0] tail_bits;
        if (!in_message)
        begin
            acc_hash   = s;
            acc_len    = '0;
            in_message = 1'b1;
        end
        // Counts only matter on the final beat, and anything above four saturates.
        if (!fin || cnt >= 3'd4)
        begin
            acc_hash = fold_word(acc_hash, w);
            acc_len  = acc_len + 32'd4;
        end
        else
        begin
            tail_bits = (cnt == 3'd0) ? 32'h0 : (32'hffffffff >> (32 - 8 * cnt));
            acc_hash  = acc_hash ^ scramble_k(w & tail_bits);
            acc_len   = acc_len + cnt;
        end
        if (fin)
        begin
            hash_expect_q.push_back(avalanche(acc_hash ^ acc_len));
            acc_hash   = '0;
            acc_len    = '0;
            in_message = 1'b0;
        end
    endtask

    // Prints one line per mismatch and counts every one.
    task automatic report_mismatch(input string msg);
        $display("ERROR at %0t ns: %s", $time, msg);
        mismatch_count++;
    endtask

    // Offers one beat after a random gap and returns at the edge that accepts it.
    task automatic send_beat(input logic [31:0] s, input logic [31:0] w,
                             input logic [2:0] cnt, input logic fin);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid   <= 1'b1;
        seed       <= s;
        data_word  <= w;
        byte_count <= cnt;
        last       <= fin;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        track_beat(s, w, cnt, fin);
    endtask

    // Receiver: random stalls, plus a long hold-off whenever a test asks for one.
    always @(posedge clk)
    begin
        if (stall_seq != stall_seen)
        begin
            stall_seen <= stall_seq;
            stall_left <= LONG_STALL;
            out_ready  <= 1'b0;
        end
        else if (stall_left != 0)
        begin
            stall_left <= stall_left - 1;
            out_ready  <= 1'b0;
        end
        else
        begin
            out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Compares every delivered hash with the oldest one expected.
    always @(posedge clk)
    begin
        logic [31:0] want;
        if (rst_n && out_valid && out_ready)
        begin
            if (hash_expect_q.size() == 0)
            begin
                report_mismatch($sformatf("unexpected hash %08h", hash));
            end
            else
            begin
                want = hash_expect_q.pop_front();
                if (hash !== want)
                    report_mismatch($sformatf("hash %08h, expected %08h", hash, want));
            end
        end
    end

    // Empty messages finalize the seed alone, at both ends of the seed range; full one-word messages follow.
    task automatic test_empty_messages();
        send_beat(32'h0000_0000, 32'h1234_5678, 3'd0, 1'b1);
        send_beat(32'hffff_ffff, 32'hffff_ffff, 3'd0, 1'b1);
        send_beat(32'h0000_0000, 32'h0000_0000, 3'd4, 1'b1);
        send_beat(32'hffff_ffff, 32'hffff_ffff, 3'd4, 1'b1);
    endtask

    // Tail words of one to three bytes, with junk above the valid bytes, alone and after a full word.
    task automatic test_tail_bytes();
        send_beat(32'h9747_b28c, 32'hffff_ffff, 3'd1, 1'b1);
        send_beat(32'h9747_b28c, 32'hffff_ffff, 3'd2, 1'b1);
        send_beat(32'h9747_b28c, 32'hffff_ffff, 3'd3, 1'b1);
        send_beat(32'h0000_0001, 32'h6463_6261, 3'd4, 1'b0);
        send_beat(32'hdead_beef, 32'haa00_0065, 3'd1, 1'b1);
    endtask

    // Counts of five to seven on the final beat act as full words.
    task automatic test_count_saturation();
        send_beat(32'h0000_0000, 32'h8000_0001, 3'd5, 1'b1);
        send_beat(32'h5555_5555, 32'h7fff_fffe, 3'd6, 1'b1);
        send_beat(32'haaaa_aaaa, 32'hffff_ffff, 3'd7, 1'b1);
    endtask

    // Short counts ahead of the final beat count as four bytes; a zero tail only finalizes.
    task automatic test_short_count_mid_message();
        send_beat(32'h0bad_cafe, 32'h0102_0304, 3'd1, 1'b0);
        send_beat(32'hffff_ffff, 32'hffff_ffff, 3'd0, 1'b0);
        send_beat(32'h0000_0000, 32'h0000_0000, 3'd7, 1'b0);
        send_beat(32'h1111_1111, 32'hcafe_f00d, 3'd0, 1'b1);
        send_beat(32'h0000_0000, 32'hffff_ffff, 3'd3, 1'b0);
        send_beat(32'h0000_0000, 32'hffff_ffff, 3'd2, 1'b1);
    endtask

    // Random messages, mostly short, now and then long, until about n beats have gone in.
    task automatic test_random_messages(input int n);
        int sent;
        int words;
        int pick;
        logic [2:0] cnt;
        sent = 0;
        while (sent < n)
        begin
            pick = $urandom_range(99);
            if (pick < 15)
                words = 1;
            else if (pick < 85)
                words = $urandom_range(8, 2);
            else
                words = $urandom_range(40, 9);
            for (int i = 0; i < words; i++)
            begin
                // Inner beats mostly carry four, but any count must be treated as four.
                if (i != words - 1 && $urandom_range(3) != 0)
                    cnt = 3'd4;
                else
                    cnt = 3'($urandom_range(7));
                send_beat($urandom, $urandom, cnt, i == words - 1);
                sent++;
            end
        end
    endtask

    // The receiver holds off for a long stretch while single-beat messages keep coming.
    task automatic test_backpressure();
        stall_seq <= stall_seq + 1;
        for (int i = 0; i < 40; i++)
            send_beat($urandom, $urandom, 3'($urandom_range(7)), 1'b1);
    endtask

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_idle_pct = 17;
        recv_idle_pct = 83;
        test_empty_messages();
        test_tail_bytes();
        test_count_saturation();
        test_short_count_mid_message();
        test_random_messages(230);

        send_idle_pct = 83;
        recv_idle_pct = 17;
        test_random_messages(230);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_backpressure();
        test_random_messages(180);

        // Let the pipeline empty out before judging.
        in_valid <= 1'b0;
        while (hash_expect_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0 && hash_expect_q.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Watchdog for a hung handshake.
    initial
    begin
        #10_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

@@ files.f @@
rtl/m3h_pkg.sv
rtl/m3h_front.sv
rtl/m3h_queue.sv
rtl/m3h_back.sv
rtl/murmur3_32_stream_hash.sv
tb/sv/tb_top.sv
